### hdl/bcpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpl_pkg: shared types and constants for the buck current PI loop
// Field widths, register codes, configuration record and loop constants.
// ----------------------------------------------------------------------------
package bcpl_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int REF_W      = 16;
  localparam int DUTY_W     = 12;
  localparam int CMP_W      = 16;
  localparam int SCMP_W     = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // (sample - offset) is 13 bit signed, gain 17 bit signed: 30 bit product
  localparam int PROD_W  = 30;
  localparam int CAL_W   = 18;
  localparam int ERR_W   = 19;
  // integrator lives in [0, 4095 << 12]; sums with 8*err fit in 26 bits
  localparam int INTEG_W = 26;
  localparam int DRAW_W  = INTEG_W - 12;

  localparam int QSHIFT   = 12;
  localparam int KP_SHIFT = 3;  // proportional gain 8
  localparam int KI_SHIFT = 1;  // integral gain 2

  localparam logic signed [INTEG_W-1:0] INTEG_FLOOR = 327680;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_OFFSET,
    REG_CAL_GAIN,
    REG_CAL_BIAS,
    REG_MAX_DUTY,
    REG_MIN_DUTY,
    REG_BOOST_DUTY,
    REG_PWM_PERIOD
  } cfg_reg_e;

  typedef struct packed {
    logic        [11:0] current_offset;
    logic        [15:0] cal_gain;
    logic signed [15:0] cal_bias;
    logic        [11:0] max_duty;
    logic        [11:0] min_duty;
    logic        [11:0] boost_duty;
    logic        [15:0] pwm_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    current_offset: 12'd0,
    cal_gain:       16'd4096,
    cal_bias:       16'sd0,
    max_duty:       12'd3891,
    min_duty:       12'd0,
    boost_duty:     12'd0,
    pwm_period:     16'd46080
  };

endpackage

### hdl/bcpl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpl_cfg_regs: configuration register file
// Seven write-only registers, written by index with no wait state.
// ----------------------------------------------------------------------------
module bcpl_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcpl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bcpl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output bcpl_pkg::cfg_t                      cfg_o
);

  bcpl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bcpl_pkg::cfg_reg_e'(cfg_index_i))
        bcpl_pkg::REG_CURRENT_OFFSET: cfg_d.current_offset = cfg_wdata_i[11:0];
        bcpl_pkg::REG_CAL_GAIN:       cfg_d.cal_gain       = cfg_wdata_i;
        bcpl_pkg::REG_CAL_BIAS:       cfg_d.cal_bias       = $signed(cfg_wdata_i);
        bcpl_pkg::REG_MAX_DUTY:       cfg_d.max_duty       = cfg_wdata_i[11:0];
        bcpl_pkg::REG_MIN_DUTY:       cfg_d.min_duty       = cfg_wdata_i[11:0];
        bcpl_pkg::REG_BOOST_DUTY:     cfg_d.boost_duty     = cfg_wdata_i[11:0];
        bcpl_pkg::REG_PWM_PERIOD:     cfg_d.pwm_period     = cfg_wdata_i;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bcpl_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/bcpl_cal_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpl_cal_stage: input register and calibration multiply
// Registers the incoming word, then registers (sample - offset) * gain.
// ----------------------------------------------------------------------------
module bcpl_cal_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bcpl_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bcpl_pkg::SAMPLE_W-1:0]       current_sample_i,
  input  logic signed [bcpl_pkg::REF_W-1:0]   current_ref_i,
  input  logic                                pwm_enable_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [bcpl_pkg::PROD_W-1:0]  product_o,
  output logic signed [bcpl_pkg::REF_W-1:0]   ref_o,
  output logic                                enable_o
);

  logic                               in_vld_q;
  logic [bcpl_pkg::SAMPLE_W-1:0]      sample_q;
  logic signed [bcpl_pkg::REF_W-1:0]  in_ref_q;
  logic                               in_en_q;

  logic                               prod_vld_q;
  logic signed [bcpl_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [bcpl_pkg::REF_W-1:0]  prod_ref_q;
  logic                               prod_en_q;

  logic                               in_ready;
  logic                               prod_ready;
  logic signed [bcpl_pkg::SAMPLE_W:0] diff;
  logic signed [16:0]                 gain_s;

  // a stage takes a word when empty or when its own word moves on
  assign prod_ready = !prod_vld_q || ready_i;
  assign in_ready   = !in_vld_q || prod_ready;
  assign in_ready_o = in_ready;

  assign diff   = $signed({1'b0, sample_q}) - $signed({1'b0, cfg_i.current_offset});
  assign gain_s = $signed({1'b0, cfg_i.cal_gain});
  assign prod_d = bcpl_pkg::PROD_W'(diff * gain_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_valid_i;
      end
      if (prod_ready) begin
        prod_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      sample_q <= current_sample_i;
      in_ref_q <= current_ref_i;
      in_en_q  <= pwm_enable_i;
    end
    if (in_vld_q && prod_ready) begin
      prod_q     <= prod_d;
      prod_ref_q <= in_ref_q;
      prod_en_q  <= in_en_q;
    end
  end

  assign valid_o   = prod_vld_q;
  assign product_o = prod_q;
  assign ref_o     = prod_ref_q;
  assign enable_o  = prod_en_q;

endmodule

### hdl/bcpl_pi_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpl_pi_stage: PI update, integrator clamp and duty clamp
// Holds the integrator and registers the clamped duty for each word.
// ----------------------------------------------------------------------------
module bcpl_pi_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bcpl_pkg::cfg_t                      cfg_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [bcpl_pkg::PROD_W-1:0]  product_i,
  input  logic signed [bcpl_pkg::REF_W-1:0]   ref_i,
  input  logic                                enable_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [bcpl_pkg::DUTY_W-1:0]         duty_o
);

  logic                                integ_vld_q;
  logic signed [bcpl_pkg::INTEG_W-1:0] integ_q, integ_d;
  logic [bcpl_pkg::DUTY_W-1:0]         duty_q, duty_d;

  logic                                ready;
  logic                                advance;
  logic signed [bcpl_pkg::CAL_W-1:0]   cal_scaled;
  logic signed [bcpl_pkg::CAL_W-1:0]   cal;
  logic signed [bcpl_pkg::ERR_W-1:0]   err;
  logic signed [bcpl_pkg::INTEG_W-1:0] err_x;
  logic signed [bcpl_pkg::INTEG_W-1:0] pi_sum;
  logic signed [bcpl_pkg::INTEG_W-1:0] integ_raw;
  logic signed [bcpl_pkg::INTEG_W-1:0] integ_floor;
  logic signed [bcpl_pkg::INTEG_W-1:0] integ_top;
  logic signed [bcpl_pkg::DRAW_W-1:0]  duty_raw;
  logic signed [bcpl_pkg::DRAW_W-1:0]  duty_max_s;
  logic signed [bcpl_pkg::DRAW_W-1:0]  duty_min_s;
  logic signed [bcpl_pkg::DRAW_W-1:0]  duty_hi;
  logic signed [bcpl_pkg::DRAW_W-1:0]  duty_lo;

  assign ready   = !integ_vld_q || ready_i;
  assign ready_o = ready;
  assign advance = valid_i && ready;

  // calibrated current and error against the reference
  assign cal_scaled = bcpl_pkg::CAL_W'(product_i >>> bcpl_pkg::QSHIFT);
  assign cal = cal_scaled + $signed({{(bcpl_pkg::CAL_W-16){cfg_i.cal_bias[15]}},
                                     cfg_i.cal_bias});
  assign err = $signed({{(bcpl_pkg::ERR_W-bcpl_pkg::REF_W){ref_i[bcpl_pkg::REF_W-1]}},
                        ref_i})
             - $signed({{(bcpl_pkg::ERR_W-bcpl_pkg::CAL_W){cal[bcpl_pkg::CAL_W-1]}}, cal});
  assign err_x = $signed({{(bcpl_pkg::INTEG_W-bcpl_pkg::ERR_W){err[bcpl_pkg::ERR_W-1]}},
                          err});

  // sum uses the integrator before this word moves it
  assign pi_sum    = integ_q + (err_x <<< bcpl_pkg::KP_SHIFT);
  assign integ_raw = integ_q + (err_x <<< bcpl_pkg::KI_SHIFT);
  assign integ_top = $signed({2'b00, cfg_i.max_duty, 12'h000});

  // floor first, ceiling last: a low max_duty wins over the floor
  assign integ_floor = (integ_raw < bcpl_pkg::INTEG_FLOOR) ? bcpl_pkg::INTEG_FLOOR
                                                           : integ_raw;
  assign integ_d     = (integ_floor > integ_top) ? integ_top : integ_floor;

  assign duty_raw   = bcpl_pkg::DRAW_W'(pi_sum >>> bcpl_pkg::QSHIFT);
  assign duty_max_s = $signed({2'b00, cfg_i.max_duty});
  assign duty_min_s = $signed({2'b00, cfg_i.min_duty});
  assign duty_hi    = (duty_raw > duty_max_s) ? duty_max_s : duty_raw;
  assign duty_lo    = (duty_hi < duty_min_s) ? duty_min_s : duty_hi;
  assign duty_d     = enable_i ? duty_lo[bcpl_pkg::DUTY_W-1:0] : cfg_i.min_duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_vld_q <= 1'b0;
      integ_q     <= '0;
    end else begin
      if (ready) begin
        integ_vld_q <= valid_i;
      end
      if (advance) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_q <= duty_d;
    end
  end

  assign valid_o = integ_vld_q;
  assign duty_o  = duty_q;

`ifndef SYNTHESIS
  a_integ_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (integ_q <= $past(integ_top)))
    else $error("integrator above max_duty ceiling after update");

  a_integ_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q >= 0)
    else $error("integrator went negative");

  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(integ_q))
    else $error("integrator moved without a word");

  a_disabled_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !enable_i) |=> (duty_q == $past(cfg_i.min_duty)))
    else $error("disabled PWM did not force minimum duty");
`endif

endmodule

### hdl/bcpl_cmp_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpl_cmp_stage: timer compare values and output register
// Scales duties by the PWM period and holds the result word for the sink.
// ----------------------------------------------------------------------------
module bcpl_cmp_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bcpl_pkg::cfg_t                      cfg_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [bcpl_pkg::DUTY_W-1:0]         duty_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bcpl_pkg::DUTY_W-1:0]         buck_duty_o,
  output logic [bcpl_pkg::CMP_W-1:0]          buck_compare_o,
  output logic [bcpl_pkg::SCMP_W-1:0]         sample_compare_o,
  output logic [bcpl_pkg::CMP_W-1:0]          boost_compare_o
);

  localparam int MulW = bcpl_pkg::DUTY_W + bcpl_pkg::CMP_W;

  logic                          out_vld_q;
  logic [bcpl_pkg::DUTY_W-1:0]   duty_q;
  logic [bcpl_pkg::CMP_W-1:0]    bcmp_q, bcmp_d;
  logic [bcpl_pkg::CMP_W-1:0]    bst_q, bst_d;

  logic                          ready;
  logic [MulW-1:0]               buck_prod;
  logic [MulW-1:0]               boost_prod;

  assign ready   = !out_vld_q || out_ready_i;
  assign ready_o = ready;

  assign buck_prod  = MulW'(duty_i) * MulW'(cfg_i.pwm_period);
  assign boost_prod = MulW'(cfg_i.boost_duty) * MulW'(cfg_i.pwm_period);
  assign bcmp_d     = buck_prod[MulW-1:bcpl_pkg::QSHIFT];
  // boost_duty < 1.0 in Q12, so the scaled term never exceeds the period
  assign bst_d      = cfg_i.pwm_period - boost_prod[MulW-1:bcpl_pkg::QSHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ready) begin
      out_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready) begin
      duty_q <= duty_i;
      bcmp_q <= bcmp_d;
      bst_q  <= bst_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign buck_duty_o      = duty_q;
  assign buck_compare_o   = bcmp_q;
  assign sample_compare_o = bcmp_q[bcpl_pkg::CMP_W-1:1];
  assign boost_compare_o  = bst_q;

endmodule

### hdl/buck_current_pi_loop_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buck_current_pi_loop_core: PI current regulator for a buck stage
// Calibrates each ADC sample, runs the PI loop and emits duty and compares.
// ----------------------------------------------------------------------------
// Takes one ADC sample word per clock while the output is not stalled and
// returns one result word per sample. With no output stall the result word
// passes through the four registers in turn before the sink can take it.
// The four registers are the input register, the calibration multiply, the PI
// stage and the compare/output register. The integrator is updated within the
// PI stage, so back-to-back samples each see the integrator left by the
// one before.
// Each stage holds its word while the next is full, so a result waiting on the
// output does not stop new samples until all four stages are occupied.
// Configuration registers are read by several stages and are meant to be
// written only while no sample is in flight.
module buck_current_pi_loop_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcpl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bcpl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bcpl_pkg::SAMPLE_W-1:0]       current_sample_i,
  input  logic signed [bcpl_pkg::REF_W-1:0]   current_ref_i,
  input  logic                                pwm_enable_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bcpl_pkg::DUTY_W-1:0]         buck_duty_o,
  output logic [bcpl_pkg::CMP_W-1:0]          buck_compare_o,
  output logic [bcpl_pkg::SCMP_W-1:0]         sample_compare_o,
  output logic [bcpl_pkg::CMP_W-1:0]          boost_compare_o
);

  bcpl_pkg::cfg_t                      cfg;

  logic                                cal_valid;
  logic                                cal_ready;
  logic signed [bcpl_pkg::PROD_W-1:0]  cal_product;
  logic signed [bcpl_pkg::REF_W-1:0]   cal_ref;
  logic                                cal_enable;

  logic                                pi_valid;
  logic                                pi_ready;
  logic [bcpl_pkg::DUTY_W-1:0]         pi_duty;

  bcpl_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcpl_cal_stage u_cal_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .current_sample_i (current_sample_i),
    .current_ref_i    (current_ref_i),
    .pwm_enable_i     (pwm_enable_i),
    .valid_o          (cal_valid),
    .ready_i          (cal_ready),
    .product_o        (cal_product),
    .ref_o            (cal_ref),
    .enable_o         (cal_enable)
  );

  bcpl_pi_stage u_pi_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (cal_valid),
    .ready_o   (cal_ready),
    .product_i (cal_product),
    .ref_i     (cal_ref),
    .enable_i  (cal_enable),
    .valid_o   (pi_valid),
    .ready_i   (pi_ready),
    .duty_o    (pi_duty)
  );

  bcpl_cmp_stage u_cmp_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (pi_valid),
    .ready_o          (pi_ready),
    .duty_i           (pi_duty),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .buck_duty_o      (buck_duty_o),
    .buck_compare_o   (buck_compare_o),
    .sample_compare_o (sample_compare_o),
    .boost_compare_o  (boost_compare_o)
  );

endmodule

### sim/tb_buck_current_pi_loop_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buck_current_pi_loop_core: self-checking bench for the PI current loop
// Drives ADC sample words and register writes, predicts every result word in
// a scoreboard that models calibration, PI sum and integrator clamps, and
// checks duty and compare fields in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_buck_current_pi_loop_core;

  localparam int LOOP_KP     = 8;
  localparam int LOOP_KI     = 2;
  localparam int LOOP_FLOOR  = 327680;
  localparam int Q_BITS      = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_NS    = 4_000_000;
  localparam logic [bcpl_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [bcpl_pkg::DUTY_W-1:0] duty;
    logic [bcpl_pkg::CMP_W-1:0]  bcmp;
    logic [bcpl_pkg::SCMP_W-1:0] scmp;
    logic [bcpl_pkg::CMP_W-1:0]  bst;
  } loop_result_t;

  class loop_scoreboard;
    bcpl_pkg::cfg_t regs;
    longint         integ;
    loop_result_t   expected_q[$];
    int             mismatches;

    function new();
      regs       = bcpl_pkg::CFG_RESET;
      integ      = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [bcpl_pkg::CFG_IDX_W-1:0] idx,
                            logic [bcpl_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bcpl_pkg::REG_CURRENT_OFFSET: regs.current_offset = val[11:0];
        bcpl_pkg::REG_CAL_GAIN:       regs.cal_gain       = val;
        bcpl_pkg::REG_CAL_BIAS:       regs.cal_bias       = val;
        bcpl_pkg::REG_MAX_DUTY:       regs.max_duty       = val[11:0];
        bcpl_pkg::REG_MIN_DUTY:       regs.min_duty       = val[11:0];
        bcpl_pkg::REG_BOOST_DUTY:     regs.boost_duty     = val[11:0];
        bcpl_pkg::REG_PWM_PERIOD:     regs.pwm_period     = val;
        default: ;
      endcase
    endfunction

    function longint calibrate(logic [bcpl_pkg::SAMPLE_W-1:0] raw);
      longint diff, off, gain, bias;
      diff = longint'(raw);
      off  = longint'(regs.current_offset);
      gain = longint'(regs.cal_gain);
      bias = longint'(regs.cal_bias);
      diff = diff - off;
      return ((diff * gain) >>> Q_BITS) + bias;
    endfunction

    function void note_sample(logic [bcpl_pkg::SAMPLE_W-1:0] raw,
                              logic signed [bcpl_pkg::REF_W-1:0] setpoint, logic en);
      longint err, sum, top, nxt, duty, mx, mn, sp;
      longint unsigned dv, prd, bd, prod;
      loop_result_t r;
      sp  = longint'(setpoint);
      err = sp - calibrate(raw);
      sum = integ + err * LOOP_KP;
      mx  = longint'(regs.max_duty);
      mn  = longint'(regs.min_duty);
      top = mx <<< Q_BITS;
      // integrator: floor first, ceiling last
      nxt = integ + err * LOOP_KI;
      if (nxt < LOOP_FLOOR) nxt = LOOP_FLOOR;
      if (nxt > top) nxt = top;
      integ = nxt;
      duty = sum >>> Q_BITS;
      if (duty > mx) duty = mx;
      if (duty < mn) duty = mn;
      if (!en) duty = mn;
      r.duty = duty[11:0];
      dv     = 64'(r.duty);
      prd    = 64'(regs.pwm_period);
      bd     = 64'(regs.boost_duty);
      prod   = (dv * prd) >> Q_BITS;
      r.bcmp = prod[15:0];
      r.scmp = r.bcmp[15:1];
      prod   = (bd * prd) >> Q_BITS;
      r.bst  = prd[15:0] - prod[15:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [bcpl_pkg::DUTY_W-1:0] duty,
                               logic [bcpl_pkg::CMP_W-1:0] bcmp,
                               logic [bcpl_pkg::SCMP_W-1:0] scmp,
                               logic [bcpl_pkg::CMP_W-1:0] bst);
      loop_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result word with nothing pending: duty %0d bcmp %0d", duty, bcmp);
        return;
      end
      exp_r = expected_q.pop_front();
      if (duty !== exp_r.duty || bcmp !== exp_r.bcmp || scmp !== exp_r.scmp ||
          bst !== exp_r.bst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: duty %0d/%0d buck_cmp %0d/%0d sample_cmp %0d/%0d boost_cmp %0d/%0d (exp/got)",
                   exp_r.duty, duty, exp_r.bcmp, bcmp, exp_r.scmp, scmp, exp_r.bst, bst);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni           = 1'b0;
  logic                              cfg_we_i         = 1'b0;
  logic [bcpl_pkg::CFG_IDX_W-1:0]    cfg_index_i      = '0;
  logic [bcpl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i      = '0;
  logic                              in_valid_i       = 1'b0;
  logic                              in_ready_o;
  logic [bcpl_pkg::SAMPLE_W-1:0]     current_sample_i = '0;
  logic signed [bcpl_pkg::REF_W-1:0] current_ref_i    = '0;
  logic                              pwm_enable_i     = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i      = 1'b0;
  logic [bcpl_pkg::DUTY_W-1:0]       buck_duty_o;
  logic [bcpl_pkg::CMP_W-1:0]        buck_compare_o;
  logic [bcpl_pkg::SCMP_W-1:0]       sample_compare_o;
  logic [bcpl_pkg::CMP_W-1:0]        boost_compare_o;

  logic hold_req      = 1'b0;
  int   send_idle_pct = 15;
  int   take_idle_pct = 86;

  loop_scoreboard sb = new();

  buck_current_pi_loop_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .current_sample_i (current_sample_i),
    .current_ref_i    (current_ref_i),
    .pwm_enable_i     (pwm_enable_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .buck_duty_o      (buck_duty_o),
    .buck_compare_o   (buck_compare_o),
    .sample_compare_o (sample_compare_o),
    .boost_compare_o  (boost_compare_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL buck_current_pi_loop_core");
    $finish;
  end

  // predict on every accepted sample word, check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(buck_duty_o, buck_compare_o, sample_compare_o, boost_compare_o);
      if (in_valid_i && in_ready_o)
        sb.note_sample(current_sample_i, current_ref_i, pwm_enable_i);
    end
  end

  // result side: random stalls, plus a long hold-off on each toggle of hold_req
  initial begin : take_side
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= take_idle_pct);
      end
    end
  end

  task automatic offer_sample(input logic [bcpl_pkg::SAMPLE_W-1:0] raw,
                              input logic signed [bcpl_pkg::REF_W-1:0] setpoint,
                              input logic en);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    current_sample_i <= raw;
    current_ref_i    <= setpoint;
    pwm_enable_i     <= en;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  task automatic write_loop_reg(input logic [bcpl_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bcpl_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid and hold until every pending result word has been taken
  task automatic wait_loop_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic pick_loop_setting();
    int pick;
    pick = $urandom_range(0, 9);
    write_loop_reg(bcpl_pkg::REG_CURRENT_OFFSET, (pick == 0) ? 16'd0 :
                   (pick == 1) ? 16'd4095 : 16'($urandom_range(0, 4095)));
    pick = $urandom_range(0, 9);
    write_loop_reg(bcpl_pkg::REG_CAL_GAIN, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                   (pick < 5) ? 16'd4096 : 16'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 9);
    write_loop_reg(bcpl_pkg::REG_CAL_BIAS, (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF :
                   16'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 9);
    // max below 80 puts its ceiling under the integrator floor
    write_loop_reg(bcpl_pkg::REG_MAX_DUTY, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd4095 :
                   (pick == 2) ? 16'($urandom_range(0, 79)) :
                   16'($urandom_range(80, 4095)));
    pick = $urandom_range(0, 9);
    write_loop_reg(bcpl_pkg::REG_MIN_DUTY, (pick == 0) ? 16'($urandom_range(0, 4095)) :
                   (pick == 1) ? 16'd4095 : 16'($urandom_range(0, 300)));
    pick = $urandom_range(0, 9);
    write_loop_reg(bcpl_pkg::REG_BOOST_DUTY, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd4095 :
                   16'($urandom_range(0, 4095)));
    pick = $urandom_range(0, 9);
    write_loop_reg(bcpl_pkg::REG_PWM_PERIOD, (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
                   16'($urandom_range(1, 65535)));
    if ($urandom_range(0, 3) == 0)
      write_loop_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
  endtask

  // bursts with a steady error ramp the integrator; a few bursts are pure noise
  task automatic send_sample_bursts(input int n);
    int          sent, blen, mode, span, delta, s;
    longint      target;
    logic [11:0] base;
    sent = 0;
    while (sent < n) begin
      blen = $urandom_range(4, 40);
      mode = $urandom_range(0, 9);
      base = 12'($urandom_range(0, 4095));
      case ($urandom_range(0, 2))
        0:       span = 64;
        1:       span = 2000;
        default: span = 24000;
      endcase
      delta  = $urandom_range(0, 2 * span);
      delta  = delta - span;
      target = sb.calibrate(base) + longint'(delta);
      if (target > 32767) target = 32767;
      if (target < -32768) target = -32768;
      for (int k = 0; k < blen && sent < n; k++) begin
        if (mode < 7) begin
          s = int'(base);
          s = s + int'($urandom_range(0, 16)) - 8;
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          offer_sample(s[11:0], target[15:0], $urandom_range(0, 19) != 0);
        end else begin
          offer_sample(12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
        end
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes, enable both ways
    offer_sample(12'd0,    16'sh8000, 1'b1);
    offer_sample(12'd4095, 16'sh7FFF, 1'b1);
    offer_sample(12'd2048, 16'sd2048, 1'b1);
    offer_sample(12'd0,    16'sd0,    1'b0);
    offer_sample(12'd4095, 16'sh8000, 1'b1);
    offer_sample(12'd100,  16'sh7FFF, 1'b0);
    wait_loop_idle();

    // ceiling under the integrator floor, register extremes
    write_loop_reg(bcpl_pkg::REG_CURRENT_OFFSET, 16'd4095);
    write_loop_reg(bcpl_pkg::REG_CAL_GAIN,       16'hFFFF);
    write_loop_reg(bcpl_pkg::REG_CAL_BIAS,       16'h8000);
    write_loop_reg(bcpl_pkg::REG_MAX_DUTY,       16'd10);
    write_loop_reg(bcpl_pkg::REG_BOOST_DUTY,     16'd4095);
    write_loop_reg(bcpl_pkg::REG_PWM_PERIOD,     16'hFFFF);
    offer_sample(12'd0,    16'sh7FFF, 1'b1);
    offer_sample(12'd4095, 16'sh8000, 1'b1);
    offer_sample(12'd2000, 16'sd0,    1'b1);
    wait_loop_idle();

    // minimum above maximum, shortest nonzero period
    write_loop_reg(bcpl_pkg::REG_CURRENT_OFFSET, 16'd0);
    write_loop_reg(bcpl_pkg::REG_CAL_GAIN,       16'd0);
    write_loop_reg(bcpl_pkg::REG_CAL_BIAS,       16'h7FFF);
    write_loop_reg(bcpl_pkg::REG_MAX_DUTY,       16'd1000);
    write_loop_reg(bcpl_pkg::REG_MIN_DUTY,       16'd3000);
    write_loop_reg(bcpl_pkg::REG_BOOST_DUTY,     16'd2048);
    write_loop_reg(bcpl_pkg::REG_PWM_PERIOD,     16'd1);
    offer_sample(12'd1000, 16'sd0,    1'b1);
    offer_sample(12'd0,    16'sh7FFF, 1'b1);
    offer_sample(12'd4095, 16'sh8000, 1'b0);
    wait_loop_idle();

    // zero period, and a write to an unmapped index that must change nothing
    write_loop_reg(bcpl_pkg::REG_CAL_GAIN,   16'd4096);
    write_loop_reg(bcpl_pkg::REG_CAL_BIAS,   16'd0);
    write_loop_reg(bcpl_pkg::REG_MAX_DUTY,   16'd4095);
    write_loop_reg(bcpl_pkg::REG_MIN_DUTY,   16'd0);
    write_loop_reg(bcpl_pkg::REG_PWM_PERIOD, 16'd0);
    write_loop_reg(REG_UNMAPPED,             16'hFFFF);
    offer_sample(12'd500,  16'sd1000,  1'b1);
    offer_sample(12'd500,  16'sd30000, 1'b1);
    offer_sample(12'd500,  16'sd30000, 1'b0);
    offer_sample(12'd4095, 16'sh7FFF,  1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          take_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          take_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        wait_loop_idle();
        pick_loop_setting();
        // stall the result side while samples keep coming, so the pipe backs up
        if (phase == 2 && seg == 1) hold_req <= ~hold_req;
        send_sample_bursts(103);
      end
    end

    wait_loop_idle();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS buck_current_pi_loop_core");
    end else begin
      $display("FAIL buck_current_pi_loop_core");
    end
    $finish;
  end

endmodule
